@@ rtl/core/lpct_pkg.sv @@
`default_nettype none
package lpct_pkg;

    // field and register widths
    localparam int FRAME_W = 43;
    localparam int RING_W  = 8;
    localparam int TIME_W  = 53;
    localparam int REL_W   = 17;
    localparam int HC_W    = 16;
    localparam int LINES_W = 8;

    // one sweep is 100 ms
    localparam logic [REL_W-1:0] SWEEP_US = REL_W'(100000);

    // supported laser line counts
    localparam logic [LINES_W-1:0] LINES_64  = LINES_W'(64);
    localparam logic [LINES_W-1:0] LINES_128 = LINES_W'(128);

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_HORIZON_COLUMNS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCAN_LINES      = 1'b1;

    // quotient steps of the relative time divider
    localparam int DIV_STEPS = REL_W;
    localparam int STEP_W    = 5;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage
`default_nettype wire

@@ rtl/core/lpct_fifo.sv @@
`default_nettype none
module lpct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/lpct_front.sv @@
`default_nettype none
module lpct_front #(
    parameter int COLUMN_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [lpct_pkg::HC_W-1:0]     horizon_columns,
    input  wire logic [lpct_pkg::LINES_W-1:0]  scan_lines,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          frame_start,
    input  wire logic [lpct_pkg::FRAME_W-1:0]  frame_time_ms,
    input  wire logic [lpct_pkg::RING_W-1:0]   ring,
    output logic                               push,
    output logic [lpct_pkg::FRAME_W+COLUMN_WIDTH+1:0] push_data,
    input  wire logic                          full
);

    localparam int CMP_W = (COLUMN_WIDTH > lpct_pkg::HC_W) ? COLUMN_WIDTH : lpct_pkg::HC_W;

    logic [COLUMN_WIDTH-1:0]         col_reg, col_next, base_col, step_col;
    logic                            pv_reg, pv_next, base_pv;
    logic [lpct_pkg::RING_W-1:0]     pr_reg, pr_next;
    logic                            abn_reg, abn_next, base_abn;
    logic                            accept, supported, rising, clamp;

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    // column tracking and clamp decision for the point being accepted
    always_comb begin
        base_col  = frame_start ? '0   : col_reg;
        base_pv   = frame_start ? 1'b0 : pv_reg;
        base_abn  = frame_start ? 1'b0 : abn_reg;
        supported = (scan_lines == lpct_pkg::LINES_64) || (scan_lines == lpct_pkg::LINES_128);
        // no stored ring reads as minus one, below every ring
        rising    = !base_pv || (ring > pr_reg);
        if (rising) begin
            step_col = base_col;
        end else if (base_col == {COLUMN_WIDTH{1'b1}}) begin
            step_col = base_col;
        end else begin
            step_col = base_col + COLUMN_WIDTH'(1);
        end
        clamp = CMP_W'(step_col) > CMP_W'(horizon_columns);

        col_next = col_reg;
        pv_next  = pv_reg;
        pr_next  = pr_reg;
        abn_next = abn_reg;
        push     = 1'b0;
        if (accept) begin
            if (supported) begin
                col_next = step_col;
                pv_next  = rising;
                pr_next  = ring;
                abn_next = base_abn | clamp;
                push     = 1'b1;
            end else begin
                // frame start still clears the state
                col_next = base_col;
                pv_next  = base_pv;
                abn_next = base_abn;
            end
        end
        // entry: frame time, column, clamp, flag from the lowest bit up
        push_data = {base_abn | clamp, clamp, step_col, frame_time_ms};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            pv_reg  <= 1'b0;
            pr_reg  <= '0;
            abn_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            pv_reg  <= pv_next;
            pr_reg  <= pr_next;
            abn_reg <= abn_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/lpct_back.sv @@
`default_nettype none
module lpct_back #(
    parameter int COLUMN_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [lpct_pkg::HC_W-1:0]     horizon_columns,
    input  wire logic                          empty,
    input  wire logic [lpct_pkg::FRAME_W+COLUMN_WIDTH+1:0] pop_data,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [lpct_pkg::TIME_W-1:0]        point_time_us,
    output logic [lpct_pkg::REL_W-1:0]         relative_time_us,
    output logic                               time_abnormal
);

    localparam int NUM_W = COLUMN_WIDTH + lpct_pkg::REL_W;
    localparam int DSH_W = lpct_pkg::HC_W + lpct_pkg::DIV_STEPS - 1;
    localparam int DIV_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int FRAME_W = lpct_pkg::FRAME_W;
    localparam int TIME_W  = lpct_pkg::TIME_W;
    localparam int REL_W   = lpct_pkg::REL_W;

    lpct_pkg::back_state_t state_reg, state_next;

    logic [FRAME_W-1:0]      ms_reg, ms_next;
    logic [COLUMN_WIDTH-1:0] col_reg, col_next;
    logic                    clamp_reg, clamp_next;
    logic                    abn_reg, abn_next;
    logic [TIME_W-1:0]       base_us_reg, base_us_next;
    logic [DIV_W-1:0]        num_reg, num_next;
    logic [DIV_W-1:0]        dsh_reg, dsh_next;
    logic [REL_W-1:0]        quo_reg, quo_next;
    logic [lpct_pkg::STEP_W-1:0] step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]       time_reg, time_next;
    logic [REL_W-1:0]        rel_reg, rel_next;
    logic                    flag_reg, flag_next;
    logic [REL_W-1:0]        rel;
    logic                    fits;
    logic [TIME_W-1:0]       ms_ext;

    assign out_valid        = out_valid_reg;
    assign point_time_us    = time_reg;
    assign relative_time_us = rel_reg;
    assign time_abnormal    = flag_reg;

    always_comb begin
        state_next     = state_reg;
        ms_next        = ms_reg;
        col_next       = col_reg;
        clamp_next     = clamp_reg;
        abn_next       = abn_reg;
        base_us_next   = base_us_reg;
        num_next       = num_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        time_next      = time_reg;
        rel_next       = rel_reg;
        flag_next      = flag_reg;
        pop            = 1'b0;
        ms_ext         = TIME_W'(ms_reg);
        fits           = (num_reg >= dsh_reg);

        // result register empties on a transfer
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        // zero columns give zero even for a zero divisor
        if (clamp_reg) begin
            rel = lpct_pkg::SWEEP_US;
        end else if (col_reg == '0) begin
            rel = '0;
        end else begin
            rel = quo_reg;
        end

        case (state_reg)
            lpct_pkg::BK_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    ms_next    = pop_data[FRAME_W-1:0];
                    col_next   = pop_data[FRAME_W +: COLUMN_WIDTH];
                    clamp_next = pop_data[FRAME_W + COLUMN_WIDTH];
                    abn_next   = pop_data[FRAME_W + COLUMN_WIDTH + 1];
                    state_next = lpct_pkg::BK_MUL;
                end
            end
            lpct_pkg::BK_MUL: begin
                // numerator and ms to us: 1000 = 1024 - 16 - 8
                num_next     = DIV_W'(NUM_W'(col_reg) * NUM_W'(lpct_pkg::SWEEP_US));
                dsh_next     = DIV_W'(horizon_columns) << (lpct_pkg::DIV_STEPS - 1);
                quo_next     = '0;
                step_next    = lpct_pkg::STEP_W'(lpct_pkg::DIV_STEPS - 1);
                base_us_next = (ms_ext << 10) - (ms_ext << 4) - (ms_ext << 3);
                state_next   = lpct_pkg::BK_DIV;
            end
            lpct_pkg::BK_DIV: begin
                // one restoring step; quotient stays below 2^17 when not clamped
                if (fits) begin
                    num_next = num_reg - dsh_reg;
                end
                quo_next = {quo_reg[REL_W-2:0], fits};
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0) begin
                    state_next = lpct_pkg::BK_OUT;
                end else begin
                    step_next = step_reg - lpct_pkg::STEP_W'(1);
                end
            end
            lpct_pkg::BK_OUT: begin
                if (!out_valid_reg || out_ready) begin
                    out_valid_next = 1'b1;
                    time_next      = base_us_reg + TIME_W'(rel);
                    rel_next       = rel;
                    flag_next      = abn_reg;
                    state_next     = lpct_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = lpct_pkg::BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lpct_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        ms_reg      <= ms_next;
        col_reg     <= col_next;
        clamp_reg   <= clamp_next;
        abn_reg     <= abn_next;
        base_us_reg <= base_us_next;
        num_reg     <= num_next;
        dsh_reg     <= dsh_next;
        quo_reg     <= quo_next;
        time_reg    <= time_next;
        rel_reg     <= rel_next;
        flag_reg    <= flag_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/lidar_point_column_timestamper.sv @@
`default_nettype none
// Lidar point column timestamper. Points come in on the s_axis stream
// (frame_start in tuser); each point whose line count setting is 64 or 128
// yields one result on m_axis with the absolute point time in microseconds,
// the relative time within the 100 ms sweep and the sticky per-frame
// abnormal flag in tuser. Points under any other line count give no result.
// The front end takes one point per cycle while its two-entry queue has room;
// the back end works on one result at a time (queue pop, multiply, 17
// steps of the shift-subtract divider for column * 100000 / horizon_columns,
// result load, which waits for a free m_axis slot) and takes the next point
// only after that load. Write cfg registers only while the block is idle:
// index 0 is horizon_columns (reset 1800), index 1 is scan_lines (reset 64).
module lidar_point_column_timestamper #(
    parameter int COLUMN_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [lpct_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lpct_pkg::HC_W-1:0]          cfg_wdata,
    // point input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [55:0]                        s_axis_tdata,  // frame_time_ms, ring, zero pad
    input  wire logic                               s_axis_tuser,  // frame_start
    // timestamp output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [71:0]                             m_axis_tdata,  // point_time_us, relative_time_us, zero pad
    output logic                                    m_axis_tuser   // time_abnormal
);

    localparam int ENTRY_W = lpct_pkg::FRAME_W + COLUMN_WIDTH + 2;

    logic [lpct_pkg::HC_W-1:0]    hc_reg, hc_next;
    logic [lpct_pkg::LINES_W-1:0] lines_reg, lines_next;
    logic                         push, pop, full, empty;
    logic [ENTRY_W-1:0]           push_data, pop_data;
    logic [lpct_pkg::TIME_W-1:0]  point_time_us;
    logic [lpct_pkg::REL_W-1:0]   relative_time_us;

    // configuration registers
    always_comb begin
        hc_next    = hc_reg;
        lines_next = lines_reg;
        if (cfg_we) begin
            case (cfg_index)
                lpct_pkg::REG_HORIZON_COLUMNS: hc_next    = cfg_wdata;
                lpct_pkg::REG_SCAN_LINES:      lines_next = cfg_wdata[lpct_pkg::LINES_W-1:0];
                default: begin
                    hc_next    = hc_reg;
                    lines_next = lines_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hc_reg    <= lpct_pkg::HC_W'(1800);
            lines_reg <= lpct_pkg::LINES_64;
        end else begin
            hc_reg    <= hc_next;
            lines_reg <= lines_next;
        end
    end

    lpct_front #(
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .horizon_columns (hc_reg),
        .scan_lines      (lines_reg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .frame_start     (s_axis_tuser),
        .frame_time_ms   (s_axis_tdata[lpct_pkg::FRAME_W-1:0]),
        .ring            (s_axis_tdata[lpct_pkg::FRAME_W +: lpct_pkg::RING_W]),
        .push            (push),
        .push_data       (push_data),
        .full            (full)
    );

    lpct_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (2)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    lpct_back #(
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .horizon_columns  (hc_reg),
        .empty            (empty),
        .pop_data         (pop_data),
        .pop              (pop),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .point_time_us    (point_time_us),
        .relative_time_us (relative_time_us),
        .time_abnormal    (m_axis_tuser)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {2'b00, relative_time_us, point_time_us};

endmodule
`default_nettype wire
